// ===== rtl/core/dq_pkg.sv =====
package dq_pkg;

  localparam int WordW  = 32;
  localparam int FuncW  = 2;
  localparam int StatW  = 2;
  localparam int CountW = 5;

  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_e;

  typedef enum logic [StatW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Operation broadcast to every cell of the row
  typedef struct packed {
    logic  en;
    func_e func;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/dq_if.sv =====
// Request channel: one operation per beat
interface dq_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  func;
  logic signed [31:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

// Response channel: one result per request beat
interface dq_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] popped_value;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic        [4:0]  entry_count;
  logic               is_empty;

  modport source (output valid, output status, output popped_value, output front_value,
                  output back_value, output entry_count, output is_empty, input ready);
  modport sink   (input valid, input status, input popped_value, input front_value,
                  input back_value, input entry_count, input is_empty, output ready);
endinterface

// ===== rtl/core/dq_cell.sv =====
module dq_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dq_pkg::cell_ctrl_t        ctrl_i,
  input  logic [dq_pkg::WordW-1:0]  push_value_i,
  input  logic [dq_pkg::WordW-1:0]  prev_data_i,
  input  logic                      prev_valid_i,
  input  logic [dq_pkg::WordW-1:0]  next_data_i,
  input  logic                      next_valid_i,
  output logic [dq_pkg::WordW-1:0]  data_o,
  output logic                      valid_o,
  output logic                      is_back_o
);
  import dq_pkg::*;

  logic [WordW-1:0] data_q, data_d;
  logic             valid_q, valid_d;

  assign is_back_o = valid_q & ~next_valid_i;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (ctrl_i.en) begin
      case (ctrl_i.func)
        FUNC_PUSH_FRONT: begin
          data_d  = prev_data_i;
          valid_d = prev_valid_i;
        end
        FUNC_PUSH_BACK: begin
          // claim the first free slot
          if (!valid_q && prev_valid_i) begin
            data_d  = push_value_i;
            valid_d = 1'b1;
          end
        end
        FUNC_POP_FRONT: begin
          data_d  = next_data_i;
          valid_d = next_valid_i;
        end
        default: begin
          if (is_back_o) valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit words held in a row of DEPTH cells.
// Cell 0 always holds the front word and the occupied cells form a contiguous run
// from cell 0; a push at the front or a pop at the front shifts the whole row by
// one place, a push at the back fills the first free cell and a pop at the back
// clears the last occupied cell. Each request beat yields exactly one registered
// response beat, carrying the status, the popped word, the new front and back
// words, the count (low five bits) and an empty flag. A request is taken in every
// cycle in which the response register is empty or is being drained, so the block
// sustains one operation per clock. Pops on an empty queue and pushes on a full
// queue change nothing and report their status.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_req_if.sink   req_i,
  dq_rsp_if.source rsp_o
);
  import dq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  // Row state, extended by one dummy cell past the back end
  logic [WordW-1:0] data_ext  [0:DEPTH];
  logic [DEPTH:0]   valid_ext;
  logic [DEPTH:0]   back_ext;

  logic [CntW-1:0]  cnt_q, cnt_d;

  // Response register
  logic             rsp_valid_q;
  status_e          rsp_status_q, rsp_status_d;
  logic [WordW-1:0] rsp_popped_q, rsp_popped_d;
  logic [WordW-1:0] rsp_front_q, rsp_front_d;
  logic [WordW-1:0] rsp_back_q, rsp_back_d;
  logic [CountW-1:0] rsp_count_q;
  logic             rsp_empty_q;

  logic             accept;
  logic             reject;
  logic             is_empty, is_full, is_single;
  func_e            func;
  logic [WordW-1:0] push_value;
  logic [WordW-1:0] back_cur, prev_cur;
  logic [31:0]      cnt_ext;
  cell_ctrl_t       cell_ctrl;

  assign func       = func_e'(req_i.func);
  assign push_value = req_i.push_value;

  // Take a new beat whenever the response slot frees up this cycle
  assign req_i.ready = ~rsp_valid_q | rsp_o.ready;
  assign accept      = req_i.valid & req_i.ready;

  assign is_empty  = (cnt_q == '0);
  assign is_full   = (cnt_q == CntW'(DEPTH));
  assign is_single = (cnt_q == CntW'(1));

  // Drop pushes on a full row and pops on an empty one
  always_comb begin
    case (func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: reject = is_full;
      default:                         reject = is_empty;
    endcase
  end

  assign cell_ctrl.en   = accept & ~reject;
  assign cell_ctrl.func = func;

  // Dummy cell past the back end: never occupied
  assign data_ext[DEPTH]  = '0;
  assign valid_ext[DEPTH] = 1'b0;
  assign back_ext[DEPTH]  = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WordW-1:0] prev_data;
    logic             prev_valid;

    // Cell 0 sees the incoming word as its front neighbor
    if (i == 0) begin : g_head
      assign prev_data  = push_value;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_data  = data_ext[i-1];
      assign prev_valid = valid_ext[i-1];
    end

    dq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .push_value_i (push_value),
      .prev_data_i  (prev_data),
      .prev_valid_i (prev_valid),
      .next_data_i  (data_ext[i+1]),
      .next_valid_i (valid_ext[i+1]),
      .data_o       (data_ext[i]),
      .valid_o      (valid_ext[i]),
      .is_back_o    (back_ext[i])
    );
  end

  // Gather the back word and the word just ahead of it; at most one back flag is set
  always_comb begin
    back_cur = '0;
    prev_cur = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_cur = back_cur | (data_ext[i] & {WordW{back_ext[i]}});
      prev_cur = prev_cur | (data_ext[i] & {WordW{back_ext[i+1]}});
    end
  end

  // Result of the operation, worked out from the state before it
  always_comb begin
    rsp_status_d = STATUS_OK;
    rsp_popped_d = '0;
    rsp_front_d  = is_empty ? '0 : data_ext[0];
    rsp_back_d   = is_empty ? '0 : back_cur;
    cnt_d        = cnt_q;
    case (func)
      FUNC_PUSH_FRONT: begin
        if (is_full) begin
          rsp_status_d = STATUS_FULL;
        end else begin
          rsp_front_d = push_value;
          if (is_empty) rsp_back_d = push_value;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      FUNC_PUSH_BACK: begin
        if (is_full) begin
          rsp_status_d = STATUS_FULL;
        end else begin
          rsp_back_d = push_value;
          if (is_empty) rsp_front_d = push_value;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      FUNC_POP_FRONT: begin
        if (is_empty) begin
          rsp_status_d = STATUS_EMPTY;
        end else begin
          rsp_popped_d = data_ext[0];
          rsp_front_d  = is_single ? '0 : data_ext[1];
          rsp_back_d   = is_single ? '0 : back_cur;
          cnt_d        = cnt_q - CntW'(1);
        end
      end
      default: begin
        if (is_empty) begin
          rsp_status_d = STATUS_EMPTY;
        end else begin
          rsp_popped_d = back_cur;
          rsp_front_d  = is_single ? '0 : data_ext[0];
          rsp_back_d   = is_single ? '0 : prev_cur;
          cnt_d        = cnt_q - CntW'(1);
        end
      end
    endcase
  end

  assign cnt_ext = 32'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) cnt_q <= cnt_d;
      // Hold the beat until taken, refill on accept
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_status_q <= rsp_status_d;
      rsp_popped_q <= rsp_popped_d;
      rsp_front_q  <= rsp_front_d;
      rsp_back_q   <= rsp_back_d;
      rsp_count_q  <= cnt_ext[CountW-1:0];
      rsp_empty_q  <= (cnt_d == '0);
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.popped_value = rsp_popped_q;
  assign rsp_o.front_value  = rsp_front_q;
  assign rsp_o.back_value   = rsp_back_q;
  assign rsp_o.entry_count  = rsp_count_q;
  assign rsp_o.is_empty     = rsp_empty_q;

  // Occupied cells match the count and start at cell 0
  a_count_matches_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_ext) == int'(cnt_q))
    else $error("occupied cells disagree with count");

  a_front_occupied : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_ext[0] == !is_empty)
    else $error("front cell occupancy disagrees with count");

  a_reject_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && reject) |=> $stable(cnt_q) && $stable(valid_ext))
    else $error("rejected operation changed the row");

  a_one_back_cell : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(back_ext) && ($countones(back_ext) == (is_empty ? 0 : 1)))
    else $error("back cell not unique");

  a_accept_fills_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_valid_q)
    else $error("accepted request produced no response");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import dq_pkg::*;

  localparam int Depth   = 16;
  localparam int IdxW    = $clog2(Depth);
  localparam int IdlePct = 14;

  // One response beat as the block should present it
  typedef struct {
    status_e            status;
    logic signed [31:0] popped;
    logic signed [31:0] front;
    logic signed [31:0] back;
    logic        [4:0]  fill;
    logic               empty;
  } deque_result_t;

  logic clk;
  logic rst_n;

  dq_req_if req_bus ();
  dq_rsp_if rsp_bus ();

  double_ended_queue #(
    .DEPTH(Depth)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // Shadow copy of the deque: ring of words, head index and fill level
  logic signed [31:0] shadow_words[Depth];
  logic [IdxW-1:0]    shadow_head;
  logic [4:0]         shadow_fill;

  deque_result_t pending_results[$];
  int            mismatch_count;
  bit            calm;  // suppress idling on both sides

  always #10 clk = ~clk;

  // Hold every input at a known value from time zero
  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.func       = FUNC_PUSH_FRONT;
    req_bus.push_value = '0;
    rsp_bus.ready      = 1'b0;
    calm               = 1'b0;
    mismatch_count     = 0;
    shadow_head        = '0;
    shadow_fill        = '0;
    foreach (shadow_words[i]) shadow_words[i] = '0;
  end

  // Compute the response to one operation and advance the shadow state.
  // Pops on empty and pushes on full leave the state alone.
  function automatic deque_result_t predict_deque_op(func_e op, logic signed [31:0] word);
    deque_result_t   res;
    logic [IdxW-1:0] tail;
    res.status = STATUS_OK;
    res.popped = '0;
    res.front  = '0;
    res.back   = '0;
    case (op)
      FUNC_PUSH_FRONT: begin
        if (shadow_fill >= Depth) begin
          res.status = STATUS_FULL;
        end else begin
          // Decrement wraps naturally in IdxW bits; an empty deque counts too
          shadow_head               = shadow_head - 1'b1;
          shadow_words[shadow_head] = word;
          shadow_fill               = shadow_fill + 1'b1;
        end
      end
      FUNC_PUSH_BACK: begin
        if (shadow_fill >= Depth) begin
          res.status = STATUS_FULL;
        end else begin
          tail               = shadow_head + IdxW'(shadow_fill);
          shadow_words[tail] = word;
          shadow_fill        = shadow_fill + 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (shadow_fill == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.popped  = shadow_words[shadow_head];
          shadow_head = shadow_head + 1'b1;
          shadow_fill = shadow_fill - 1'b1;
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          tail        = shadow_head + IdxW'(shadow_fill - 1'b1);
          res.popped  = shadow_words[tail];
          shadow_fill = shadow_fill - 1'b1;
        end
      end
    endcase
    // Only the occupied window is read, so no unwritten entry leaks out
    if (shadow_fill != 0) begin
      tail      = shadow_head + IdxW'(shadow_fill - 1'b1);
      res.front = shadow_words[shadow_head];
      res.back  = shadow_words[tail];
    end
    res.fill  = shadow_fill;
    res.empty = (shadow_fill == 0);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got 0x%08h, want 0x%08h", name, got, want));
  endtask

  // Drive one request beat. Called at a falling edge, returns at a falling
  // edge; the expectation is queued at the rising edge that accepts the beat.
  task automatic send_op(func_e op, logic signed [31:0] word);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.valid      = 1'b1;
    req_bus.func       = op;
    req_bus.push_value = word;
    // Hold the beat until ready is seen high at a rising edge
    do @(posedge clk); while (!req_bus.ready);
    pending_results.push_back(predict_deque_op(op, word));
    @(negedge clk);
  endtask

  // Random word, leaning on the extremes now and then so that every bit
  // toggles and the sign boundary gets exercised
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Response side: stall at random, except in calm stretches
  always @(negedge clk) begin
    if (rst_n) begin
      rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Compare every accepted response beat against the oldest expectation
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("response beat with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(rsp_bus.status), 32'(want.status));
        check_field("popped_value", rsp_bus.popped_value, want.popped);
        check_field("front_value", rsp_bus.front_value, want.front);
        check_field("back_value", rsp_bus.back_value, want.back);
        check_field("entry_count", 32'(rsp_bus.entry_count), 32'(want.fill));
        check_field("is_empty", 32'(rsp_bus.is_empty), 32'(want.empty));
      end
    end
  end

  // Both pop flavors straight out of reset must report empty
  task automatic test_empty_pops();
    send_op(FUNC_POP_FRONT, 32'sh7fff_ffff);
    send_op(FUNC_POP_BACK, '1);
  endtask

  // Push at front onto an empty deque has to be counted
  task automatic test_front_push_on_empty();
    send_op(FUNC_PUSH_FRONT, 32'sh8000_0000);
    send_op(FUNC_POP_FRONT, '0);
  endtask

  // Fill to the brim from both ends, overflow both ways, then pop both ends
  task automatic test_fill_to_full();
    logic signed [31:0] edge_words[4];
    edge_words = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1};
    for (int i = 0; i < Depth; i++) begin
      send_op(i[0] ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT,
              (i < 4) ? edge_words[i] : pick_word());
    end
    send_op(FUNC_PUSH_FRONT, 32'sh1234_5678);
    send_op(FUNC_PUSH_BACK, 32'sh8765_4321);
    send_op(FUNC_POP_BACK, '0);
    send_op(FUNC_POP_FRONT, '0);
  endtask

  // Random walk over the fill level; push_pct steers toward full or empty
  task automatic test_random_walk(int n_items, int push_pct);
    func_e op;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < push_pct)
        op = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
      else
        op = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
      send_op(op, pick_word());
    end
  endtask

  // Long stretch at full rate on both sides
  task automatic test_back_to_back();
    calm = 1'b1;
    test_random_walk(100, 55);
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_pops();
    test_front_push_on_empty();
    test_fill_to_full();
    test_random_walk(60, 80);
    test_random_walk(60, 20);
    test_random_walk(60, 50);
    test_random_walk(60, 85);
    test_random_walk(80, 15);
    test_back_to_back();
    test_random_walk(60, 50);
    test_random_walk(60, 70);

    req_bus.valid = 1'b0;
    // Drain: wait for every expectation, then let the pipe settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
